>>> sv/assert_macros.svh
// assertion macros used by the controller rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked property, disabled while the active-low reset is asserted
`define ASSERT_CLK_RSTN(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked property, evaluated at every edge including reset
`define ASSERT_CLK(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK_RSTN(name, clk, rstn, prop, msg)

`define ASSERT_CLK(name, clk, prop, msg)

`endif

`endif

>>> sv/led_pbc_pkg.sv
// types and codes for the led pulse / blink controller
// no dependencies
`timescale 1ns / 1ps

package led_pbc_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_FIXED   = 3'd1,
        MODE_PULSE   = 3'd2,
        MODE_ENDLESS = 3'd3,
        MODE_COUNTED = 3'd4
    } mode_t;

    localparam logic [2:0] FUNC_TICK  = 3'd0;
    localparam logic [2:0] FUNC_PULSE = 3'd1;
    localparam logic [2:0] FUNC_BLINK = 3'd2;
    localparam logic [2:0] FUNC_FIXED = 3'd3;
    localparam logic [2:0] FUNC_OFF   = 3'd4;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CYCLE_W = 8;

endpackage

>>> sv/led_pulse_blink_controller_unit.sv
// led pulse / blink controller: 1 ms ticks and commands in, pin state out
// uses led_pbc_pkg and assert_macros.svh
//
// an item passes the input register and the result register; a stall holds it in the input register
// throughput: one item per cycle unless stalled; each item updates the state in a single pass
// reset (aresetn low, synchronous): mode idle, led off, counters and times zero,
// active level 1, both pipeline registers empty
`timescale 1ns / 1ps
`include "assert_macros.svh"

module led_pulse_blink_controller_unit (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic                                  cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [2:0]                            s_func,
    input  logic                                  s_level,
    input  logic [led_pbc_pkg::TIME_W-1:0]        s_first_ms,
    input  logic [led_pbc_pkg::TIME_W-1:0]        s_second_ms,
    input  logic signed [led_pbc_pkg::CYCLE_W-1:0] s_cycle_count,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic                                  m_pin_out,
    output logic                                  m_lit,
    output logic [2:0]                            m_mode,
    output logic                                  m_expired
);
    import led_pbc_pkg::*;

    // configuration
    logic active_level_reg;

    // input register
    logic                      in_valid_reg;
    logic [2:0]                in_func_reg;
    logic                      in_level_reg;
    logic [TIME_W-1:0]         in_first_reg;
    logic [TIME_W-1:0]         in_second_reg;
    logic [CYCLE_W-1:0]        in_cycle_reg;

    // controller state
    logic [TIME_W-1:0]  now_count_reg,   now_count_next;
    logic [TIME_W-1:0]  mark_time_reg,   mark_time_next;
    logic [TIME_W-1:0]  pulse_len_reg,   pulse_len_next;
    logic [TIME_W-1:0]  on_len_reg,      on_len_next;
    logic [TIME_W-1:0]  off_len_reg,     off_len_next;
    logic [CYCLE_W-1:0] cycles_left_reg, cycles_left_next;
    mode_t              mode_reg,        mode_next;
    logic               led_reg,         led_next;
    logic               expired_next;

    // result register
    logic        m_valid_reg;
    logic        m_pin_out_reg,  m_pin_out_next;
    logic        m_lit_reg,      m_lit_next;
    logic [2:0]  m_mode_reg,     m_mode_next;
    logic        m_expired_reg;

    logic               advance;
    logic [TIME_W-1:0]  tick_now;
    logic [TIME_W-1:0]  elapsed;
    logic [CYCLE_W-1:0] cycles_dec;
    logic               blinking;
    logic               cycle_positive;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign tick_now       = now_count_reg + TIME_W'(1);
    assign elapsed        = tick_now - mark_time_reg;
    assign cycles_dec     = cycles_left_reg - CYCLE_W'(1);
    assign blinking       = (mode_reg == MODE_ENDLESS) || (mode_reg == MODE_COUNTED);
    assign cycle_positive = !in_cycle_reg[CYCLE_W-1] && (in_cycle_reg != '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= 1'b1;
        end else if (cfg_we) begin
            active_level_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_func_reg   <= s_func;
            in_level_reg  <= s_level;
            in_first_reg  <= s_first_ms;
            in_second_reg <= s_second_ms;
            in_cycle_reg  <= s_cycle_count;
        end
    end

    // next state of the controller for the item in the input register
    always_comb begin
        now_count_next   = now_count_reg;
        mark_time_next   = mark_time_reg;
        pulse_len_next   = pulse_len_reg;
        on_len_next      = on_len_reg;
        off_len_next     = off_len_reg;
        cycles_left_next = cycles_left_reg;
        mode_next        = mode_reg;
        led_next         = led_reg;
        expired_next     = 1'b0;

        unique case (in_func_reg)
            FUNC_TICK: begin
                now_count_next = tick_now;
                if (mode_reg == MODE_PULSE) begin
                    if (elapsed >= pulse_len_reg) begin
                        mode_next        = MODE_IDLE;
                        led_next         = 1'b0;
                        cycles_left_next = '0;
                        expired_next     = 1'b1;
                    end
                end else if (blinking) begin
                    if (led_reg) begin
                        if (elapsed >= on_len_reg) begin
                            led_next       = 1'b0;
                            mark_time_next = tick_now;
                        end
                    end else if (elapsed >= off_len_reg) begin
                        led_next       = 1'b1;
                        mark_time_next = tick_now;
                        if (mode_reg == MODE_COUNTED) begin
                            cycles_left_next = cycles_dec;
                            // count ran out (or wrapped negative): finish
                            if ((cycles_dec == '0) || cycles_dec[CYCLE_W-1]) begin
                                mode_next        = MODE_IDLE;
                                led_next         = 1'b0;
                                cycles_left_next = '0;
                                expired_next     = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_PULSE: begin
                if (mode_reg != MODE_PULSE) begin
                    mode_next        = MODE_PULSE;
                    cycles_left_next = '0;
                    pulse_len_next   = in_first_reg;
                    mark_time_next   = now_count_reg;
                    led_next         = 1'b1;
                end
            end
            FUNC_BLINK: begin
                if (!blinking) begin
                    if (cycle_positive) begin
                        mode_next        = MODE_COUNTED;
                        cycles_left_next = in_cycle_reg;
                    end else begin
                        mode_next        = MODE_ENDLESS;
                        cycles_left_next = '0;
                    end
                    on_len_next    = in_first_reg;
                    off_len_next   = in_second_reg;
                    mark_time_next = now_count_reg;
                    led_next       = 1'b1;
                end
            end
            FUNC_FIXED: begin
                mode_next        = MODE_FIXED;
                cycles_left_next = '0;
                led_next         = in_level_reg;
            end
            FUNC_OFF: begin
                if (blinking) begin
                    mode_next        = MODE_FIXED;
                    cycles_left_next = '0;
                    led_next         = 1'b0;
                end
            end
            default: begin
                // unused codes leave the state alone
            end
        endcase
    end

    // result fields
    always_comb begin
        m_pin_out_next = led_next ? active_level_reg : ~active_level_reg;
        m_lit_next     = led_next;
        m_mode_next    = mode_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_count_reg   <= '0;
            mark_time_reg   <= '0;
            pulse_len_reg   <= '0;
            on_len_reg      <= '0;
            off_len_reg     <= '0;
            cycles_left_reg <= '0;
            mode_reg        <= MODE_IDLE;
            led_reg         <= 1'b0;
        end else if (advance) begin
            now_count_reg   <= now_count_next;
            mark_time_reg   <= mark_time_next;
            pulse_len_reg   <= pulse_len_next;
            on_len_reg      <= on_len_next;
            off_len_reg     <= off_len_next;
            cycles_left_reg <= cycles_left_next;
            mode_reg        <= mode_next;
            led_reg         <= led_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pin_out_reg <= m_pin_out_next;
            m_lit_reg     <= m_lit_next;
            m_mode_reg    <= m_mode_next;
            m_expired_reg <= expired_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_pin_out = m_pin_out_reg;
    assign m_lit     = m_lit_reg;
    assign m_mode    = m_mode_reg;
    assign m_expired = m_expired_reg;

    // an expiry always leaves the led idle and dark
    `ASSERT_CLK_RSTN(a_expired_idle, aclk, aresetn,
        (m_valid_reg && m_expired_reg) |-> ((m_mode_reg == MODE_IDLE) && !m_lit_reg),
        "expired result not idle and dark")

    // idle never keeps the led lit
    `ASSERT_CLK(a_idle_dark, aclk, (mode_reg == MODE_IDLE) |-> !led_reg, "led lit while idle")

    // only a counted blink carries a cycle count
    `ASSERT_CLK(a_cycles_counted, aclk,
        (mode_reg != MODE_COUNTED) |-> (cycles_left_reg == '0),
        "cycle count outside counted blink")

    // a tick transfer advances the millisecond counter by exactly one
    `ASSERT_CLK_RSTN(a_tick_count, aclk, aresetn,
        (advance && (in_func_reg == FUNC_TICK)) |=>
            (now_count_reg == TIME_W'($past(now_count_reg) + TIME_W'(1))),
        "ms counter did not step on tick")

endmodule

>>> sim/tb_top.sv
// self-checking testbench for led_pulse_blink_controller_unit
// drives ticks and commands, mostly under random valid/ready gaps; checks each result against a
// typed row or a behavioral model of the pulse/blink timer; uses led_pbc_pkg and the unit rtl
`timescale 1ns / 1ps

module tb_top;
    import led_pbc_pkg::*;

    localparam logic [2:0] FUNC_RSVD5 = 3'd5;
    localparam logic [2:0] FUNC_RSVD7 = 3'd7;
    localparam logic [TIME_W-1:0] MS_MAX = '1;
    localparam logic [CYCLE_W-1:0] CYCLES_MIN = 8'h80;   // -128
    localparam logic [CYCLE_W-1:0] CYCLES_MAX = 8'h7f;   // 127
    localparam logic [CYCLE_W-1:0] CYCLES_NEG1 = 8'hff;
    localparam int PHASE_ITEMS = 310;

    typedef struct packed {
        logic [2:0]         func;
        logic               level;
        logic [TIME_W-1:0]  first_ms;
        logic [TIME_W-1:0]  second_ms;
        logic [CYCLE_W-1:0] cycle_count;
    } led_cmd_t;

    typedef struct packed {
        logic  pin_out;
        logic  lit;
        mode_t mode;
        logic  expired;
    } led_state_t;

    typedef struct {
        led_cmd_t   cmd;
        bit         typed;
        led_state_t want;
    } cmd_row_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic                      cfg_wdata = 1'b1;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [2:0]                s_func = FUNC_TICK;
    logic                      s_level = 1'b0;
    logic [TIME_W-1:0]         s_first_ms = '0;
    logic [TIME_W-1:0]         s_second_ms = '0;
    logic signed [CYCLE_W-1:0] s_cycle_count = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_pin_out;
    logic                      m_lit;
    logic [2:0]                m_mode;
    logic                      m_expired;

    // timer model state, reset values
    logic [TIME_W-1:0]  ms_now = '0;
    logic [TIME_W-1:0]  stamp_ms = '0;
    logic [TIME_W-1:0]  pulse_ms = '0;
    logic [TIME_W-1:0]  lit_ms = '0;
    logic [TIME_W-1:0]  dark_ms = '0;
    logic [CYCLE_W-1:0] blinks_left = '0;
    mode_t              cur_mode = MODE_IDLE;
    logic               led_on = 1'b0;
    logic               lit_level = 1'b1;

    led_state_t states_due[$];
    led_state_t due_state;
    cmd_row_t   directed_rows[$];
    int         mismatches = 0;
    int         n_results = 0;
    bit         no_gaps = 1'b0;

    led_pulse_blink_controller_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_level       (s_level),
        .s_first_ms    (s_first_ms),
        .s_second_ms   (s_second_ms),
        .s_cycle_count (s_cycle_count),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pin_out     (m_pin_out),
        .m_lit         (m_lit),
        .m_mode        (m_mode),
        .m_expired     (m_expired)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // applies one item to the timer model and returns the led state it leaves
    function automatic led_state_t next_led_state(input led_cmd_t cmd);
        led_state_t        st;
        logic [TIME_W-1:0] elapsed;
        bit                blinking;
        blinking = (cur_mode == MODE_ENDLESS) || (cur_mode == MODE_COUNTED);
        st.expired = 1'b0;
        unique case (cmd.func)
            FUNC_TICK: begin
                ms_now = ms_now + 1'b1;
                elapsed = ms_now - stamp_ms;
                if (cur_mode == MODE_PULSE) begin
                    if (elapsed >= pulse_ms) begin
                        cur_mode = MODE_IDLE;
                        led_on = 1'b0;
                        blinks_left = '0;
                        st.expired = 1'b1;
                    end
                end else if (blinking) begin
                    if (led_on) begin
                        if (elapsed >= lit_ms) begin
                            led_on = 1'b0;
                            stamp_ms = ms_now;
                        end
                    end else if (elapsed >= dark_ms) begin
                        led_on = 1'b1;
                        stamp_ms = ms_now;
                        // only dark-to-lit edges use up a counted cycle
                        if (cur_mode == MODE_COUNTED) begin
                            blinks_left = blinks_left - 1'b1;
                            if (blinks_left == '0 || blinks_left[CYCLE_W-1]) begin
                                cur_mode = MODE_IDLE;
                                led_on = 1'b0;
                                blinks_left = '0;
                                st.expired = 1'b1;
                            end
                        end
                    end
                end
            end
            FUNC_PULSE: begin
                if (cur_mode != MODE_PULSE) begin
                    cur_mode = MODE_PULSE;
                    blinks_left = '0;
                    pulse_ms = cmd.first_ms;
                    stamp_ms = ms_now;
                    led_on = 1'b1;
                end
            end
            FUNC_BLINK: begin
                if (!blinking) begin
                    if ($signed(cmd.cycle_count) > 8'sd0) begin
                        cur_mode = MODE_COUNTED;
                        blinks_left = cmd.cycle_count;
                    end else begin
                        cur_mode = MODE_ENDLESS;
                        blinks_left = '0;
                    end
                    lit_ms = cmd.first_ms;
                    dark_ms = cmd.second_ms;
                    stamp_ms = ms_now;
                    led_on = 1'b1;
                end
            end
            FUNC_FIXED: begin
                cur_mode = MODE_FIXED;
                blinks_left = '0;
                led_on = cmd.level;
            end
            FUNC_OFF: begin
                if (blinking) begin
                    cur_mode = MODE_FIXED;
                    blinks_left = '0;
                    led_on = 1'b0;
                end
            end
            default: begin
            end
        endcase
        st.pin_out = led_on ? lit_level : ~lit_level;
        st.lit = led_on;
        st.mode = cur_mode;
        return st;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input logic [2:0] got,
                                 input logic [2:0] want);
        if (got !== want)
            log_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                   n_results, name, got, want));
    endtask

    // result side: random stalls (none while no_gaps is set) plus the check of every transfer
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 29);
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (states_due.size() == 0) begin
                log_mismatch($sformatf("result %0d arrived with nothing expected", n_results));
            end else begin
                due_state = states_due.pop_front();
                compare_field("pin_out", 3'(m_pin_out), 3'(due_state.pin_out));
                compare_field("lit", 3'(m_lit), 3'(due_state.lit));
                compare_field("mode", m_mode, due_state.mode);
                compare_field("expired", 3'(m_expired), 3'(due_state.expired));
            end
        end
    end

    task automatic send_cmd(input led_cmd_t cmd, input bit typed, input led_state_t want);
        led_state_t predicted;
        if (!no_gaps) begin
            while ($urandom_range(99) < 29) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_func <= cmd.func;
        s_level <= cmd.level;
        s_first_ms <= cmd.first_ms;
        s_second_ms <= cmd.second_ms;
        s_cycle_count <= cmd.cycle_count;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = next_led_state(cmd);
        states_due.push_back(typed ? want : predicted);
    endtask

    task automatic add_row(input logic [2:0] func, input logic level,
                           input logic [TIME_W-1:0] first_ms,
                           input logic [TIME_W-1:0] second_ms,
                           input logic [CYCLE_W-1:0] cycles, input bit typed,
                           input logic pin, input logic lit, input mode_t md,
                           input logic expired);
        cmd_row_t row;
        row.cmd = '{func, level, first_ms, second_ms, cycles};
        row.typed = typed;
        row.want = '{pin, lit, md, expired};
        directed_rows.push_back(row);
    endtask

    // mostly short times so that phases end; now and then a huge one
    function automatic logic [TIME_W-1:0] pick_ms();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return $urandom_range(5);
        else if (pick < 95)
            return $urandom_range(40, 6);
        return $urandom;
    endfunction

    function automatic led_cmd_t random_cmd(input bit tick_only);
        led_cmd_t c;
        int       pick;
        c.func = FUNC_TICK;
        c.level = 1'($urandom_range(1));
        c.first_ms = $urandom;
        c.second_ms = $urandom;
        c.cycle_count = CYCLE_W'($urandom_range(255));
        if (!tick_only) begin
            pick = $urandom_range(99);
            if (pick < 30) begin
                c.func = FUNC_PULSE;
                c.first_ms = pick_ms();
            end else if (pick < 70) begin
                c.func = FUNC_BLINK;
                c.first_ms = pick_ms();
                c.second_ms = pick_ms();
                if ($urandom_range(99) < 70)
                    c.cycle_count = CYCLE_W'($urandom_range(4, 1));
            end else if (pick < 82) begin
                c.func = FUNC_FIXED;
            end else if (pick < 94) begin
                c.func = FUNC_OFF;
            end else begin
                c.func = 3'($urandom_range(FUNC_RSVD7, FUNC_RSVD5));
            end
        end
        return c;
    endfunction

    // drain, change the active level, then a command followed by a burst of ticks, repeated
    task automatic run_phase(input logic level, input int n_items);
        int sent;
        int ticks;
        sent = 0;
        s_valid <= 1'b0;
        while (states_due.size() != 0) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= level;
        @(posedge aclk);
        cfg_we <= 1'b0;
        lit_level = level;
        while (sent < n_items) begin
            send_cmd(random_cmd(1'b0), 1'b0, '0);
            sent++;
            ticks = $urandom_range(25);
            repeat (ticks) begin
                send_cmd(random_cmd(1'b1), 1'b0, '0);
                sent++;
            end
        end
    endtask

    initial begin
        // active level is 1 here; typed rows give the state at a glance
        add_row(FUNC_TICK,  0, '0, '0, '0, 1, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_RSVD5, 1, MS_MAX, MS_MAX, CYCLES_NEG1, 1, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_OFF,   1, '0, '0, '0, 1, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_FIXED, 1, '0, '0, '0, 1, 1, 1, MODE_FIXED, 0);
        add_row(FUNC_FIXED, 0, '0, '0, '0, 1, 0, 0, MODE_FIXED, 0);
        // zero-length pulse, a repeat that is ignored, and its end on the next tick
        add_row(FUNC_PULSE, 0, '0, '0, '0, 1, 1, 1, MODE_PULSE, 0);
        add_row(FUNC_PULSE, 0, MS_MAX, '0, '0, 1, 1, 1, MODE_PULSE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 1, 0, 0, MODE_IDLE, 1);
        add_row(FUNC_PULSE, 1, MS_MAX, '0, '0, 1, 1, 1, MODE_PULSE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        // endless blink with zero phases, then a blink that is ignored
        add_row(FUNC_BLINK, 0, '0, '0, CYCLES_MIN, 1, 1, 1, MODE_ENDLESS, 0);
        add_row(FUNC_BLINK, 1, MS_MAX, MS_MAX, CYCLES_MAX, 1, 1, 1, MODE_ENDLESS, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_OFF,   1, '0, '0, '0, 1, 0, 0, MODE_FIXED, 0);
        // one counted cycle: dark, then the relight ends it
        add_row(FUNC_BLINK, 0, '0, '0, 8'd1, 1, 1, 1, MODE_COUNTED, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_BLINK, 0, 32'd2, 32'd1, '0, 1, 1, 1, MODE_ENDLESS, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        // a pulse cancels a blink; a blink then starts from the pulse
        add_row(FUNC_PULSE, 0, 32'd3, '0, '0, 1, 1, 1, MODE_PULSE, 0);
        add_row(FUNC_BLINK, 0, 32'd1, MS_MAX, CYCLES_MAX, 1, 1, 1, MODE_COUNTED, 0);
        add_row(FUNC_FIXED, 1, '0, '0, '0, 1, 1, 1, MODE_FIXED, 0);
        add_row(FUNC_RSVD7, 0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);
        add_row(FUNC_TICK,  0, '0, '0, '0, 0, 0, 0, MODE_IDLE, 0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);

        run_phase(1'b0, PHASE_ITEMS);
        no_gaps = 1'b1;
        run_phase(1'b1, PHASE_ITEMS);
        no_gaps = 1'b0;
        run_phase(1'b0, PHASE_ITEMS);
        run_phase(1'b1, PHASE_ITEMS);

        s_valid <= 1'b0;
        while (states_due.size() != 0) @(posedge aclk);
        // catch any stray transfer after the last expected one
        repeat (8) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+sv
sv/led_pbc_pkg.sv
sv/led_pulse_blink_controller_unit.sv
sim/tb_top.sv
